>>> rtl/core/lcpu_pkg.sv
// ----------------------------------------------------------------------------
// lcpu_pkg: shared constants for the lstm pointwise update core
// register indexes and the rate format of the zoneout mixers
// ----------------------------------------------------------------------------
`default_nettype none
package lcpu_pkg;
	localparam int RATE_BITS = 12;
	localparam int RATE_W    = 13;
	localparam int IDX_W     = 2;
	localparam logic [IDX_W-1:0] REG_FORGET_BIAS = 2'd0;
	localparam logic [IDX_W-1:0] REG_ZC_RATE     = 2'd1;
	localparam logic [IDX_W-1:0] REG_ZO_RATE     = 2'd2;
	localparam logic [RATE_W-1:0] RATE_ONE = 13'd4096;
endpackage
`default_nettype wire

>>> rtl/core/lcpu_sigmoid.sv
// ----------------------------------------------------------------------------
// lcpu_sigmoid: piecewise linear sigmoid, or 2*sigmoid(x)-1 in tanh mode
// four-segment approximation on |x|, mirrored for negative x
// ----------------------------------------------------------------------------
`default_nettype none
module lcpu_sigmoid #(
	parameter int IN_W      = 18,
	parameter int FRAC_BITS = 12
) (
	input  wire logic signed [IN_W-1:0]        x,
	input  wire logic                          tanh_mode,
	output logic signed [FRAC_BITS+2:0]        y
);
	localparam int OW = FRAC_BITS + 2;
	localparam logic [IN_W:0] ONE  = (IN_W+1)'(1) << FRAC_BITS;
	localparam logic [IN_W:0] T5   = (IN_W+1)'(5) << FRAC_BITS;
	localparam logic [IN_W:0] T238 = (IN_W+1)'((19 << FRAC_BITS) >> 3);
	localparam logic [OW-1:0] C27  = OW'((27 << FRAC_BITS) >> 5);
	localparam logic [OW-1:0] C58  = OW'((5 << FRAC_BITS) >> 3);
	localparam logic [OW-1:0] C12  = OW'(1 << (FRAC_BITS - 1));
	localparam logic [OW-1:0] OW1  = OW'(1) << FRAC_BITS;

	logic [IN_W:0]   a;
	logic [OW-1:0]   s;
	logic [OW-1:0]   sg;
	logic            neg;

	// magnitude, segment select, mirror for negative x and tanh mapping
	always_comb begin
		neg = x[IN_W-1];
		a = neg ? -{x[IN_W-1], x} : {x[IN_W-1], x};
		if (a >= T5) begin
			s = OW1;
		end else if (a >= T238) begin
			s = OW'(a >> 5) + C27;
		end else if (a >= ONE) begin
			s = OW'(a >> 3) + C58;
		end else begin
			s = OW'(a >> 2) + C12;
		end
		sg = neg ? OW1 - s : s;
		y = tanh_mode ? $signed({sg, 1'b0}) - $signed({1'b0, OW1})
			: $signed({1'b0, sg});
	end
endmodule
`default_nettype wire

>>> rtl/core/lstm_cell_pointwise_update_core.sv
// ----------------------------------------------------------------------------
// lstm_cell_pointwise_update_core: lstm pointwise cell and hidden update
// gate activations, cell update, hidden output and zoneout mixing
// ----------------------------------------------------------------------------
// One hidden unit per cycle: a transaction enters every clock while the
// output is not stalled. Each result passes through the activation, cell
// product, cell round, hidden and zoneout product, mix and output register
// stages; a stalled output holds all stages in place.
// Configuration writes apply to transactions accepted after the write.
`default_nettype none
module lstm_cell_pointwise_update_core #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [lcpu_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [15:0]                  cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [DATA_WIDTH-1:0] input_gate_pre,
	input  wire logic signed [DATA_WIDTH-1:0] candidate_pre,
	input  wire logic signed [DATA_WIDTH-1:0] forget_gate_pre,
	input  wire logic signed [DATA_WIDTH-1:0] output_gate_pre,
	input  wire logic signed [DATA_WIDTH-1:0] cell_prev,
	input  wire logic signed [DATA_WIDTH-1:0] hidden_prev,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0]      cell_next,
	output logic signed [DATA_WIDTH-1:0]      hidden_out,
	output logic signed [DATA_WIDTH-1:0]      hidden_next
);
	localparam int DW = DATA_WIDTH;
	localparam int GW = FRAC_BITS + 3;        // gate width, signed
	localparam int PW = DW + GW;              // product width
	localparam int RB = lcpu_pkg::RATE_BITS;
	localparam int RW = lcpu_pkg::RATE_W;
	localparam int MW = DW + RW + 2;          // zoneout accumulator
	localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [PW+1:0] RND  = (PW+2)'(1) << (FRAC_BITS - 1);
	localparam logic signed [MW-1:0] RNDZ = MW'(1) << (RB - 1);
	localparam int NS = 6;

	// configuration registers
	logic signed [15:0] forget_bias_q;
	logic [RW-1:0]      zc_rate_q, zo_rate_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forget_bias_q <= '0;
			zc_rate_q     <= '0;
			zo_rate_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lcpu_pkg::REG_FORGET_BIAS: forget_bias_q <= cfg_data;
				lcpu_pkg::REG_ZC_RATE:     zc_rate_q <= cfg_data[RW-1:0];
				lcpu_pkg::REG_ZO_RATE:     zo_rate_q <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control: whole pipe advances unless output stalled
	logic [NS-1:0] vld_q;
	logic          adv;
	assign adv       = !vld_q[NS-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[NS-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[NS-2:0], in_valid};
	end

	// saturating rate clip
	function automatic logic [RW-1:0] clip_rate(input logic [RW-1:0] r);
		clip_rate = (r > lcpu_pkg::RATE_ONE) ? lcpu_pkg::RATE_ONE : r;
	endfunction
	function automatic logic signed [DW-1:0] sat_p(input logic signed [PW+1:0] v);
		if (v > PW'(SMAX) + (PW+2)'(0)) sat_p = SMAX;
		else if (v < $signed({{(PW+2-DW){1'b1}}, SMIN})) sat_p = SMIN;
		else sat_p = v[DW-1:0];
	endfunction

	// stage 1: activations
	localparam int XW = DW + 2;
	logic signed [XW-1:0] xf, xi2, xi, xo;
	logic signed [GW-1:0] gi, gf, go, gg;
	assign xf  = XW'(forget_gate_pre) + XW'(forget_bias_q);
	assign xi  = XW'(input_gate_pre);
	assign xo  = XW'(output_gate_pre);
	assign xi2 = XW'(candidate_pre) <<< 1;
	lcpu_sigmoid #(.IN_W(XW), .FRAC_BITS(FRAC_BITS)) u_si
		(.x(xi), .tanh_mode(1'b0), .y(gi));
	lcpu_sigmoid #(.IN_W(XW), .FRAC_BITS(FRAC_BITS)) u_sf
		(.x(xf), .tanh_mode(1'b0), .y(gf));
	lcpu_sigmoid #(.IN_W(XW), .FRAC_BITS(FRAC_BITS)) u_so
		(.x(xo), .tanh_mode(1'b0), .y(go));
	lcpu_sigmoid #(.IN_W(XW), .FRAC_BITS(FRAC_BITS)) u_tg
		(.x(xi2), .tanh_mode(1'b1), .y(gg));

	logic signed [GW-1:0] gi_s1, gf_s1, go_s1, gg_s1;
	logic signed [DW-1:0] c_s1, h_s1, c_s2, h_s2, c_s3, h_s3, h_s4;
	logic [RW-1:0] zc_s1, zo_s1, zc_s2, zo_s2, zc_s3, zo_s3, zo_s4;
	logic signed [GW-1:0] go_s2, go_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			gi_s1 <= gi; gf_s1 <= gf; go_s1 <= go; gg_s1 <= gg;
			c_s1 <= cell_prev; h_s1 <= hidden_prev;
			zc_s1 <= clip_rate(zc_rate_q); zo_s1 <= clip_rate(zo_rate_q);
		end
	end

	// stage 2: cell products
	logic signed [PW-1:0] pf_s2, pi_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			pf_s2 <= PW'(c_s1) * PW'(gf_s1);
			pi_s2 <= PW'(gi_s1) * PW'(gg_s1);
			go_s2 <= go_s1; c_s2 <= c_s1; h_s2 <= h_s1;
			zc_s2 <= zc_s1; zo_s2 <= zo_s1;
		end
	end

	// stage 3: sum, round, saturate new cell
	logic signed [PW+1:0] csum;
	logic signed [DW-1:0] cell_s3;
	assign csum = ((PW+2)'(pf_s2) + (PW+2)'(pi_s2) + RND) >>> FRAC_BITS;
	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s3 <= sat_p(csum);
			go_s3 <= go_s2; c_s3 <= c_s2; h_s3 <= h_s2;
			zc_s3 <= zc_s2; zo_s3 <= zo_s2;
		end
	end

	// stage 4: tanh of cell, hidden product, cell zoneout products
	localparam int CW = DW + 2;
	logic signed [CW-1:0] cell2;
	logic signed [GW-1:0] tc;
	assign cell2 = CW'(cell_s3) <<< 1;
	lcpu_sigmoid #(.IN_W(CW), .FRAC_BITS(FRAC_BITS)) u_tc
		(.x(cell2), .tanh_mode(1'b1), .y(tc));
	logic signed [PW-1:0] ph_s4;
	logic signed [MW-1:0] zck_s4, zcn_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s4  <= PW'(go_s3) * PW'(tc);
			zck_s4 <= MW'(c_s3) * $signed({2'b00, zc_s3});
			zcn_s4 <= MW'(cell_s3) * $signed({2'b00, lcpu_pkg::RATE_ONE - zc_s3});
			h_s4 <= h_s3; zo_s4 <= zo_s3;
		end
	end

	// stage 5: hidden round, cell mix, hidden zoneout
	function automatic logic signed [DW-1:0] sat_m(input logic signed [MW-1:0] v);
		if (v > MW'(SMAX)) sat_m = SMAX;
		else if (v < MW'(SMIN)) sat_m = SMIN;
		else sat_m = v[DW-1:0];
	endfunction
	logic signed [DW-1:0] hid;
	logic signed [MW-1:0] cmix;
	assign hid  = sat_p(((PW+2)'(ph_s4) + RND) >>> FRAC_BITS);
	assign cmix = (zck_s4 + zcn_s4 + RNDZ) >>> RB;
	logic signed [DW-1:0] cn_s5, hid_s5;
	logic signed [MW-1:0] zok_s5, zon_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			cn_s5  <= sat_m(cmix);
			hid_s5 <= hid;
			zok_s5 <= MW'(h_s4) * $signed({2'b00, zo_s4});
			zon_s5 <= MW'(hid) * $signed({2'b00, lcpu_pkg::RATE_ONE - zo_s4});
		end
	end

	// stage 6: hidden zoneout mix and output register
	logic signed [MW-1:0] hmix;
	assign hmix = (zok_s5 + zon_s5 + RNDZ) >>> RB;
	always_ff @(posedge clk) begin
		if (adv) begin
			cell_next   <= cn_s5;
			hidden_out  <= hid_s5;
			hidden_next <= sat_m(hmix);
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/lcpu_checker.sv
// ----------------------------------------------------------------------------
// lcpu_checker: port-level checks for the lstm pointwise update core
// handshake and flow checks, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module lcpu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [15:0] cell_next
);
	// a pending result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_next))
		else $error("result changed while stalled");
	// input is ready whenever the output is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	// stall backs up to the input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
endmodule

bind lstm_cell_pointwise_update_core lcpu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .cell_next(cell_next));
`default_nettype wire
